// ===== rtl/mwpo_pkg.sv =====
// Package for the multi-waveform phase oscillator: shared types, codes, and the
// quarter-wave sine table, which is built at elaboration.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mwpo_pkg;

  localparam int unsigned SineDepth     = 256;
  localparam int unsigned SineIdxW      = 8;
  localparam int unsigned SampleW       = 16;
  localparam int unsigned WordW         = 64;
  localparam int unsigned ChanCntW      = 4;
  localparam int unsigned ChanIdxW      = 3;
  localparam int unsigned MaxChannels   = 8;
  localparam int unsigned AmpW          = 17;
  localparam int unsigned CfgAddrW      = 5;
  localparam int unsigned JobQueueDepth = 2;
  localparam int unsigned JobPtrW       = $clog2(JobQueueDepth);
  localparam int unsigned JobCntW       = $clog2(JobQueueDepth + 1);
  localparam logic [63:0] HalfPiQ28     = 64'd421657428;

  typedef enum logic [1:0] {
    WAVE_SAW      = 2'd0,
    WAVE_SINE     = 2'd1,
    WAVE_SQUARE   = 2'd2,
    WAVE_TRIANGLE = 2'd3
  } wave_e;

  typedef enum logic [1:0] {
    SIZE_1B = 2'd0,
    SIZE_2B = 2'd1,
    SIZE_4B = 2'd2,
    SIZE_8B = 2'd3
  } size_e;

  typedef enum logic [2:0] {
    REG_WAVEFORM      = 3'd0,
    REG_PHASE_STEP    = 3'd1,
    REG_AMPLITUDE     = 3'd2,
    REG_SAMPLE_SIZE   = 3'd3,
    REG_SIGNED_FORMAT = 3'd4,
    REG_BYTE_SWAP     = 3'd5,
    REG_CHANNEL_COUNT = 3'd6
  } reg_e;

  typedef struct packed {
    wave_e                 waveform;
    logic [AmpW-1:0]       amplitude;
    size_e                 size_code;
    logic                  signed_fmt;
    logic                  byte_swap;
    logic [ChanCntW-1:0]   channel_count;
  } cfg_t;

  // One frame's work handed from the front to the back.
  typedef struct packed {
    logic [WordW-1:0]    word;
    logic [ChanCntW-1:0] count;
    logic                eob;
  } job_t;

  typedef logic [SampleW-2:0] sine_rom_t [0:SineDepth];

  // Fixed-point Taylor series of sin over a quarter wave, Q28 angle.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] s;
    for (int k = 0; k <= SineDepth; k++) begin
      x   = (64'(k) * HalfPiQ28) / SineDepth;
      x2  = (x * x) >> 28;
      t   = ((x * x2) >> 28) / 64'd6;
      neg = t;
      t   = ((t * x2) >> 28) / 64'd20;
      pos = x + t;
      t   = ((t * x2) >> 28) / 64'd42;
      neg = neg + t;
      t   = ((t * x2) >> 28) / 64'd72;
      pos = pos + t;
      t   = ((t * x2) >> 28) / 64'd110;
      neg = neg + t;
      t   = ((t * x2) >> 28) / 64'd156;
      pos = pos + t;
      s   = (pos > neg) ? (pos - neg) : 64'd0;
      t   = (s * 64'd32767 + 64'd134217728) >> 28;
      rom[k] = (t > 64'd32767) ? 15'd32767 : t[14:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SineRom = build_sine_rom();

endpackage

`default_nettype wire

// ===== rtl/mwpo_front.sv =====
// Front of the oscillator: accepts a frame tick, advances the phase and forms
// the formatted sample word in a short multi-cycle sequence. Uses mwpo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mwpo_front import mwpo_pkg::*; #(
  parameter int unsigned PHASE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic [31:0] phase_step_i,
  input  logic        push_i,
  input  logic        end_of_buffer_i,
  output logic        full_o,
  output logic        job_push_o,
  output job_t        job_o,
  input  logic        job_full_i
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_WAVE  = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_SCALE = 6'b001000,
    ST_FMT   = 6'b010000,
    ST_PUSH  = 6'b100000
  } front_state_e;

  front_state_e state_q, state_d;

  logic [PHASE_BITS-1:0]    acc_q, acc_d;
  logic [PHASE_BITS-1:0]    phase_q;
  logic [PHASE_BITS+31:0]   step_wide;
  logic [PHASE_BITS-1:0]    step_pb;
  logic                     eob_q;
  logic [ChanCntW-1:0]      count_q;
  logic [ChanCntW-1:0]      count_sat;
  logic signed [SampleW-1:0] v_q, v_d;
  logic [31:0]              prod_q;
  logic [32:0]              prod_full;
  logic [WordW-1:0]         mag_q, mag_d;
  logic [WordW-1:0]         word_q, word_d;
  logic                     accept;

  // wave forming
  logic [SampleW-1:0]       u;
  logic [1:0]               quad;
  logic [SineIdxW-1:0]      sine_k;
  logic [SineIdxW:0]        sine_idx;
  logic signed [SampleW-1:0] sine_mag;
  logic signed [SampleW-1:0] sine_val;
  logic [SampleW-1:0]       saw_abs;
  logic signed [SampleW-1:0] tri_val;
  logic signed [SampleW-1:0] sq_val;

  // scaling
  logic [AmpW-1:0]          amp_sat;
  logic [SampleW-1:0]       v_abs;
  logic [SampleW-1:0]       mul_op;
  logic [95:0]              a_ext;
  logic [95:0]              shifted;
  logic [95:0]              diff;

  // formatting
  logic [WordW-1:0]         raw;
  logic [WordW-1:0]         m;

  assign accept    = push_i && (state_q == ST_IDLE);
  assign full_o    = (state_q != ST_IDLE);
  assign step_wide = {{PHASE_BITS{1'b0}}, phase_step_i};
  assign step_pb   = step_wide[PHASE_BITS-1:0];
  assign acc_d     = accept ? (acc_q + step_pb) : acc_q;
  assign count_sat = (cfg_i.channel_count > ChanCntW'(MaxChannels)) ?
                     ChanCntW'(MaxChannels) : cfg_i.channel_count;

  always_comb begin
    u        = phase_q[PHASE_BITS-1 -: SampleW];
    quad     = phase_q[PHASE_BITS-1 -: 2];
    sine_k   = phase_q[PHASE_BITS-3 -: SineIdxW];
    sine_idx = quad[0] ? ((SineIdxW+1)'(SineDepth) - {1'b0, sine_k}) : {1'b0, sine_k};
    sine_mag = signed'({1'b0, SineRom[sine_idx]});
    sine_val = quad[1] ? -sine_mag : sine_mag;
    saw_abs  = u[SampleW-1] ? (~u + 16'd1) : u;
    tri_val  = (saw_abs == 16'h8000) ? 16'sh7fff :
               signed'({~saw_abs[14], saw_abs[13:0], 1'b0});
    if (phase_q[PHASE_BITS-2:0] == '0) begin
      sq_val = 16'sh0000;
    end else if (phase_q[PHASE_BITS-1]) begin
      sq_val = 16'sh8000;
    end else begin
      sq_val = 16'sh7fff;
    end
    case (cfg_i.waveform)
      WAVE_SAW:      v_d = signed'(u);
      WAVE_SINE:     v_d = sine_val;
      WAVE_SQUARE:   v_d = sq_val;
      WAVE_TRIANGLE: v_d = tri_val;
      default:       v_d = signed'(u);
    endcase
  end

  // Signed: scale |v|; offset binary: scale v + 32768 (flip the sign bit).
  always_comb begin
    amp_sat   = (cfg_i.amplitude > 17'd65536) ? 17'd65536 : cfg_i.amplitude;
    v_abs     = v_q[SampleW-1] ? (~v_q + 16'd1) : v_q;
    mul_op    = cfg_i.signed_fmt ? v_abs : {~v_q[SampleW-1], v_q[SampleW-2:0]};
    prod_full = {17'd0, mul_op} * {16'd0, amp_sat};
  end

  // a * (2^k - 1) = (a << k) - a, then drop 31 or 32 bits.
  always_comb begin
    a_ext = {64'd0, prod_q};
    if (cfg_i.signed_fmt) begin
      case (cfg_i.size_code)
        SIZE_1B: shifted = a_ext << 7;
        SIZE_2B: shifted = a_ext << 15;
        SIZE_4B: shifted = a_ext << 31;
        SIZE_8B: shifted = a_ext << 63;
        default: shifted = a_ext << 7;
      endcase
    end else begin
      case (cfg_i.size_code)
        SIZE_1B: shifted = a_ext << 8;
        SIZE_2B: shifted = a_ext << 16;
        SIZE_4B: shifted = a_ext << 32;
        SIZE_8B: shifted = a_ext << 64;
        default: shifted = a_ext << 8;
      endcase
    end
    diff  = shifted - a_ext;
    mag_d = cfg_i.signed_fmt ? diff[94:31] : diff[95:32];
  end

  always_comb begin
    raw = (cfg_i.signed_fmt && v_q[SampleW-1]) ? (64'd0 - mag_q) : mag_q;
    case (cfg_i.size_code)
      SIZE_1B: m = {56'd0, raw[7:0]};
      SIZE_2B: m = {48'd0, raw[15:0]};
      SIZE_4B: m = {32'd0, raw[31:0]};
      SIZE_8B: m = raw;
      default: m = raw;
    endcase
    word_d = m;
    if (cfg_i.byte_swap) begin
      case (cfg_i.size_code)
        SIZE_1B: word_d = m;
        SIZE_2B: word_d = {48'd0, m[7:0], m[15:8]};
        SIZE_4B: word_d = {32'd0, m[7:0], m[15:8], m[23:16], m[31:24]};
        SIZE_8B: word_d = {m[7:0], m[15:8], m[23:16], m[31:24],
                           m[39:32], m[47:40], m[55:48], m[63:56]};
        default: word_d = m;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (push_i) state_d = ST_WAVE;
      ST_WAVE:  state_d = ST_MUL;
      ST_MUL:   state_d = ST_SCALE;
      ST_SCALE: state_d = ST_FMT;
      ST_FMT:   state_d = ST_PUSH;
      ST_PUSH:  if ((count_q == '0) || !job_full_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign job_push_o = (state_q == ST_PUSH) && (count_q != '0) && !job_full_i;
  assign job_o      = '{word: word_q, count: count_q, eob: eob_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      phase_q <= acc_q;
      eob_q   <= end_of_buffer_i;
      count_q <= count_sat;
    end
    if (state_q == ST_WAVE)  v_q    <= v_d;
    if (state_q == ST_MUL)   prod_q <= prod_full[31:0];
    if (state_q == ST_SCALE) mag_q  <= mag_d;
    if (state_q == ST_FMT)   word_q <= word_d;
  end

endmodule

`default_nettype wire

// ===== rtl/mwpo_job_queue.sv =====
// Short queue of frame jobs between the front and the back of the oscillator.
// Uses mwpo_pkg for the job type and depth.
`timescale 1ns / 1ps
`default_nettype none

module mwpo_job_queue import mwpo_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t data_o,
  output logic valid_o
);

  job_t               slots_q [JobQueueDepth];
  logic [JobPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [JobPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [JobCntW-1:0] cnt_q, cnt_d;
  logic               do_push;
  logic               do_pop;

  assign full_o  = (cnt_q == JobCntW'(JobQueueDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == JobPtrW'(JobQueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == JobPtrW'(JobQueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wr_ptr_q] <= data_i;
  end

endmodule

`default_nettype wire

// ===== rtl/mwpo_back.sv =====
// Back of the oscillator: takes one frame job and emits one result beat per
// channel into the output register. Uses mwpo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mwpo_back import mwpo_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  job_t                job_i,
  output logic                job_pop_o,
  output logic                empty,
  input  logic                pop,
  output logic [WordW-1:0]    sample_word_o,
  output logic [ChanIdxW-1:0] channel_index_o,
  output logic                last_of_frame_o,
  output logic                buffer_end_o
);

  job_t                cur_q;
  logic                cur_valid_q, cur_valid_d;
  logic [ChanIdxW-1:0] ch_q, ch_d;
  logic                out_valid_q, out_valid_d;
  logic                take;
  logic                emit;
  logic                is_last;

  assign take      = !cur_valid_q && job_valid_i;
  assign job_pop_o = take;
  assign emit      = cur_valid_q && (!out_valid_q || pop);
  assign is_last   = (({1'b0, ch_q} + 4'd1) == cur_q.count);
  assign empty     = !out_valid_q;

  always_comb begin
    cur_valid_d = cur_valid_q;
    ch_d        = ch_q;
    out_valid_d = out_valid_q;
    if (take) begin
      cur_valid_d = 1'b1;
      ch_d        = '0;
    end else if (emit) begin
      ch_d = ch_q + 1'b1;
      if (is_last) cur_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) cur_q <= job_i;
    if (emit) begin
      sample_word_o   <= cur_q.word;
      channel_index_o <= ch_q;
      last_of_frame_o <= is_last;
      buffer_end_o    <= is_last && cur_q.eob;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/multi_waveform_phase_oscillator.sv =====
// Top level of the multi-waveform phase oscillator: configuration registers,
// front, job queue and back. Uses mwpo_pkg, mwpo_front, mwpo_job_queue, mwpo_back.
//
//   channel   direction  handshake               beat payload
//   -------   ---------  ----------------------  ---------------------------------
//   frame     in         push / full             end_of_buffer_i
//   sample    out        empty / pop             sample_word_o, channel_index_o,
//                                                last_of_frame_o, buffer_end_o
//   config    in/out     psel, penable, pready   paddr, pwdata, prdata (byte 4*i)
//
// The front takes a frame beat only in its idle state, then steps through wave
// lookup, multiply, scale, format and hand-off before it takes the next; the
// hand-off waits while the job queue is full. The back loads a job, then emits
// one sample beat per channel per cycle while its output is empty or popped.
// The two-entry job queue lets the front work on the next frame while the back
// still drains the last one. Reset clears the phase, empties the queue and the output
// register and loads the default configuration; a stall on pop holds the back,
// then fills the queue, then holds the front in hand-off with full high.
`timescale 1ns / 1ps
`default_nettype none

module multi_waveform_phase_oscillator import mwpo_pkg::*; #(
  parameter int unsigned PHASE_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // frame ticks
  input  logic                push,
  output logic                full,
  input  logic                end_of_buffer_i,
  // samples
  output logic                empty,
  input  logic                pop,
  output logic [WordW-1:0]    sample_word_o,
  output logic [ChanIdxW-1:0] channel_index_o,
  output logic                last_of_frame_o,
  output logic                buffer_end_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t        cfg_q;
  logic [31:0] phase_step_q;
  logic        cfg_write;
  reg_e        reg_sel;

  logic        job_push;
  job_t        job_in;
  logic        job_full;
  logic        job_pop;
  job_t        job_out;
  logic        job_valid;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_sel   = reg_e'(paddr[CfgAddrW-1:2]);

  // Register writes: keep only the bits each field defines.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.waveform      <= WAVE_SINE;
      cfg_q.amplitude     <= 17'd65536;
      cfg_q.size_code     <= SIZE_2B;
      cfg_q.signed_fmt    <= 1'b1;
      cfg_q.byte_swap     <= 1'b0;
      cfg_q.channel_count <= 4'd2;
      phase_step_q        <= '0;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_WAVEFORM:      cfg_q.waveform      <= wave_e'(pwdata[1:0]);
        REG_PHASE_STEP:    phase_step_q        <= pwdata;
        REG_AMPLITUDE:     cfg_q.amplitude     <= pwdata[AmpW-1:0];
        REG_SAMPLE_SIZE:   cfg_q.size_code     <= size_e'(pwdata[1:0]);
        REG_SIGNED_FORMAT: cfg_q.signed_fmt    <= pwdata[0];
        REG_BYTE_SWAP:     cfg_q.byte_swap     <= pwdata[0];
        REG_CHANNEL_COUNT: cfg_q.channel_count <= pwdata[ChanCntW-1:0];
        default:           ;
      endcase
    end
  end

  // Read back the stored value, zero above the field.
  always_comb begin
    case (reg_sel)
      REG_WAVEFORM:      prdata = {30'd0, cfg_q.waveform};
      REG_PHASE_STEP:    prdata = phase_step_q;
      REG_AMPLITUDE:     prdata = {15'd0, cfg_q.amplitude};
      REG_SAMPLE_SIZE:   prdata = {30'd0, cfg_q.size_code};
      REG_SIGNED_FORMAT: prdata = {31'd0, cfg_q.signed_fmt};
      REG_BYTE_SWAP:     prdata = {31'd0, cfg_q.byte_swap};
      REG_CHANNEL_COUNT: prdata = {28'd0, cfg_q.channel_count};
      default:           prdata = '0;
    endcase
  end

  // Front: phase accumulator and sample word, one frame at a time.
  mwpo_front #(
    .PHASE_BITS (PHASE_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .phase_step_i    (phase_step_q),
    .push_i          (push),
    .end_of_buffer_i (end_of_buffer_i),
    .full_o          (full),
    .job_push_o      (job_push),
    .job_o           (job_in),
    .job_full_i      (job_full)
  );

  // Decouple the front from the channel fan-out.
  mwpo_job_queue u_job_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .valid_o (job_valid)
  );

  // Back: repeat the word once per channel, mark last and buffer end.
  mwpo_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (job_valid),
    .job_i           (job_out),
    .job_pop_o       (job_pop),
    .empty           (empty),
    .pop             (pop),
    .sample_word_o   (sample_word_o),
    .channel_index_o (channel_index_o),
    .last_of_frame_o (last_of_frame_o),
    .buffer_end_o    (buffer_end_o)
  );

endmodule

`default_nettype wire
